// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the weighted Stokes combiner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/swc_pkg.sv =====
// Package: types, codes and helpers for the weighted Stokes combiner.
`timescale 1ns / 1ps
package swc_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_CHANNELS = 4096;
  localparam int DEF_MAX_POLS     = 4;

  // Register indexes
  localparam logic [2:0] REG_POL_COUNT  = 3'd0;
  localparam logic [2:0] REG_POL_TYPE_0 = 3'd1;
  localparam logic [2:0] REG_POL_TYPE_1 = 3'd2;
  localparam logic [2:0] REG_POL_TYPE_2 = 3'd3;
  localparam logic [2:0] REG_POL_TYPE_3 = 3'd4;
  localparam logic [2:0] REG_OUTPUT_POL = 3'd5;
  localparam logic [2:0] REG_START_CH   = 3'd6;
  localparam logic [2:0] REG_END_CH     = 3'd7;

  // Polarization codes
  localparam logic [3:0] POL_XX = 4'd0;
  localparam logic [3:0] POL_XY = 4'd1;
  localparam logic [3:0] POL_YX = 4'd2;
  localparam logic [3:0] POL_YY = 4'd3;
  localparam logic [3:0] POL_RR = 4'd4;
  localparam logic [3:0] POL_RL = 4'd5;
  localparam logic [3:0] POL_LR = 4'd6;
  localparam logic [3:0] POL_LL = 4'd7;
  localparam logic [3:0] POL_I  = 4'd8;
  localparam logic [3:0] POL_Q  = 4'd9;
  localparam logic [3:0] POL_U  = 4'd10;
  localparam logic [3:0] POL_V  = 4'd11;

  // Combine modes
  localparam logic [2:0] MODE_NONE = 3'd0;
  localparam logic [2:0] MODE_COPY = 3'd1;
  localparam logic [2:0] MODE_SUM  = 3'd2;
  localparam logic [2:0] MODE_DIFF = 3'd3;
  localparam logic [2:0] MODE_ROT  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FLAGGED = 2'd1;
  localparam logic [1:0] ST_NOFORM  = 2'd2;

  // Decoded configuration; the user keeps it static while items flow, the block does not enforce it
  typedef struct packed {
    logic [2:0]  n_active;
    logic [2:0]  mode;
    logic [1:0]  pa;
    logic [1:0]  pb;
    logic [11:0] start_ch;
    logic [12:0] end_ch;
  } cfg_t;

  // Per-beat control carried down the pipe
  typedef struct packed {
    logic        row_start;
    logic        flagged;
    logic [1:0]  pos;
    logic        emit;
    logic [11:0] ch;
  } ctl_t;

  // Registered input beat
  typedef struct packed {
    logic signed [15:0] s_real;
    logic signed [15:0] s_imag;
    logic [15:0]        weight;
    ctl_t               ctl;
  } beat_t;

  // Weighted product beat
  typedef struct packed {
    logic signed [31:0] p_real;
    logic signed [31:0] p_imag;
    ctl_t               ctl;
  } prod_t;

  // First active position holding a code: {found, position}
  function automatic logic [2:0] find_type(input logic [3:0][3:0] types,
                                           input logic [2:0] n_active,
                                           input logic [3:0] code);
    logic [2:0] res;
    res = 3'b000;
    for (int i = 3; i >= 0; i--) begin
      if ((3'(i) < n_active) && (types[i] == code)) begin
        res = {1'b1, 2'(i)};
      end
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/swc_cfg.sv =====
// Configuration registers, APB access and mode decode.
`timescale 1ns / 1ps
module swc_cfg #(
  parameter int MAX_POLS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output swc_pkg::cfg_t      cfg
);
  import swc_pkg::*;

  localparam logic [2:0] MaxPolsW = 3'(MAX_POLS);

  logic [2:0]       pol_count_r;
  logic [3:0][3:0]  pol_type_r;
  logic [3:0]       output_pol_r;
  logic [11:0]      start_ch_r;
  logic [12:0]      end_ch_r;
  logic [2:0]       n_act;
  logic [2:0]       mode;
  logic [1:0]       pa;
  logic [1:0]       pb;
  logic [2:0]       f_out, f_c1, f_c2, f_c3, f_c4;
  logic [3:0]       c1, c2, c3, c4;
  logic [2:0]       m1, m2;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_count_r  <= 3'd4;
      pol_type_r   <= {POL_YY, POL_YX, POL_XY, POL_XX};
      output_pol_r <= POL_I;
      start_ch_r   <= 12'd0;
      end_ch_r     <= 13'd4096;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_POL_COUNT:  pol_count_r   <= pwdata[2:0];
        REG_POL_TYPE_0: pol_type_r[0] <= pwdata[3:0];
        REG_POL_TYPE_1: pol_type_r[1] <= pwdata[3:0];
        REG_POL_TYPE_2: pol_type_r[2] <= pwdata[3:0];
        REG_POL_TYPE_3: pol_type_r[3] <= pwdata[3:0];
        REG_OUTPUT_POL: output_pol_r  <= pwdata[3:0];
        REG_START_CH:   start_ch_r    <= pwdata[11:0];
        REG_END_CH:     end_ch_r      <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (paddr[4:2])
      REG_POL_COUNT:  prdata = {29'd0, pol_count_r};
      REG_POL_TYPE_0: prdata = {28'd0, pol_type_r[0]};
      REG_POL_TYPE_1: prdata = {28'd0, pol_type_r[1]};
      REG_POL_TYPE_2: prdata = {28'd0, pol_type_r[2]};
      REG_POL_TYPE_3: prdata = {28'd0, pol_type_r[3]};
      REG_OUTPUT_POL: prdata = {28'd0, output_pol_r};
      REG_START_CH:   prdata = {20'd0, start_ch_r};
      REG_END_CH:     prdata = {19'd0, end_ch_r};
      default:        prdata = 32'd0;
    endcase
  end

  // Active product count, clamped
  always_comb begin
    if (pol_count_r == 3'd0) begin
      n_act = 3'd1;
    end else if (pol_count_r > MaxPolsW) begin
      n_act = MaxPolsW;
    end else begin
      n_act = pol_count_r;
    end
  end

  // Candidate pairs per requested Stokes output
  always_comb begin
    c1 = POL_XX; c2 = POL_YY; c3 = POL_RR; c4 = POL_LL;
    m1 = MODE_SUM; m2 = MODE_SUM;
    case (output_pol_r)
      POL_Q: begin
        c1 = POL_XX; c2 = POL_YY; c3 = POL_RL; c4 = POL_LR;
        m1 = MODE_DIFF; m2 = MODE_SUM;
      end
      POL_U: begin
        c1 = POL_XY; c2 = POL_YX; c3 = POL_RL; c4 = POL_LR;
        m1 = MODE_SUM; m2 = MODE_ROT;
      end
      POL_V: begin
        c1 = POL_XY; c2 = POL_YX; c3 = POL_RR; c4 = POL_LL;
        m1 = MODE_ROT; m2 = MODE_DIFF;
      end
      default: ;
    endcase
  end

  assign f_out = find_type(pol_type_r, n_act, output_pol_r);
  assign f_c1  = find_type(pol_type_r, n_act, c1);
  assign f_c2  = find_type(pol_type_r, n_act, c2);
  assign f_c3  = find_type(pol_type_r, n_act, c3);
  assign f_c4  = find_type(pol_type_r, n_act, c4);

  // Mode and operand positions; a failed pair search still moves pa
  always_comb begin
    mode = MODE_NONE;
    pa   = 2'd0;
    pb   = 2'd0;
    if (output_pol_r <= POL_V) begin
      if (f_out[2]) begin
        mode = MODE_COPY;
        pa   = f_out[1:0];
        pb   = f_out[1:0];
      end else if (output_pol_r >= POL_I) begin
        if (f_c1[2]) pa = f_c1[1:0];
        if (f_c1[2] && f_c2[2]) begin
          pb   = f_c2[1:0];
          mode = m1;
        end else begin
          if (f_c3[2]) pa = f_c3[1:0];
          if (f_c3[2] && f_c4[2]) begin
            pb   = f_c4[1:0];
            mode = m2;
          end
        end
      end
    end
  end

  assign cfg = '{n_active: n_act, mode: mode, pa: pa, pb: pb,
                 start_ch: start_ch_r, end_ch: end_ch_r};

endmodule

// ===== hw/rtl/swc_front.sv =====
// Input register with polarization position and channel tracking.
`timescale 1ns / 1ps
module swc_front #(
  parameter int MAX_CHANNELS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  swc_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample_real,
  input  logic signed [15:0] in_sample_imag,
  input  logic [15:0]        in_weight,
  input  logic               in_flagged,
  input  logic               in_row_start,
  output logic               s1_valid,
  output swc_pkg::beat_t     s1_beat,
  input  logic               s1_take
);
  import swc_pkg::*;

  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int CMP_W = (CH_W > 13) ? CH_W : 13;
  localparam logic [CH_W-1:0] MaxCh = CH_W'(MAX_CHANNELS);

  logic [1:0]       pos_r, pos_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic [1:0]       pos_eff;
  logic [CH_W-1:0]  ch_eff;
  logic [CMP_W-1:0] ch_cmp;
  logic             last;
  logic             in_win;
  logic             ready1;
  logic             acc;
  logic             s1_valid_r;
  beat_t            s1_beat_r;

  assign ready1   = !s1_valid_r || s1_take;
  assign in_stall = !ready1;
  assign acc      = in_valid && ready1;

  // Row start restarts both counters before this beat
  assign pos_eff = in_row_start ? 2'd0 : pos_r;
  assign ch_eff  = in_row_start ? '0 : ch_r;
  assign last    = ({1'b0, pos_eff} + 3'd1) >= cfg.n_active;
  assign ch_cmp  = CMP_W'(ch_eff);
  assign in_win  = (ch_cmp >= CMP_W'(cfg.start_ch)) && (ch_cmp < CMP_W'(cfg.end_ch)) &&
                   (ch_eff < MaxCh);

  // Counter next state; channel count saturates
  always_comb begin
    pos_nxt = last ? 2'd0 : pos_eff + 2'd1;
    ch_nxt  = ch_eff;
    if (last && (ch_eff < MaxCh)) ch_nxt = ch_eff + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 2'd0;
      ch_r       <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        pos_r <= pos_nxt;
        ch_r  <= ch_nxt;
      end
      if (ready1) s1_valid_r <= in_valid;
    end
  end

  // Input payload register
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_beat_r.s_real        <= in_sample_real;
      s1_beat_r.s_imag        <= in_sample_imag;
      s1_beat_r.weight        <= in_weight;
      s1_beat_r.ctl.row_start <= in_row_start;
      s1_beat_r.ctl.flagged   <= in_flagged;
      s1_beat_r.ctl.pos       <= pos_eff;
      s1_beat_r.ctl.emit      <= last && in_win;
      s1_beat_r.ctl.ch        <= ch_cmp[11:0];
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_beat  = s1_beat_r;

endmodule

// ===== hw/rtl/swc_mult.sv =====
// Weight multiply stage: sample times weight, registered.
`timescale 1ns / 1ps
module swc_mult (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s1_valid,
  input  swc_pkg::beat_t  s1_beat,
  output logic            s1_take,
  output logic            s2_valid,
  output swc_pkg::prod_t  s2_prod,
  input  logic            s2_take
);
  import swc_pkg::*;

  logic               ready2;
  logic               s2_valid_r;
  prod_t              s2_prod_r;
  logic signed [32:0] m_real;
  logic signed [32:0] m_imag;

  assign ready2  = !s2_valid_r || s2_take;
  assign s1_take = ready2;

  // Signed Q1.15 times unsigned Q8.8, exact in 32 bits
  assign m_real = s1_beat.s_real * $signed({1'b0, s1_beat.weight});
  assign m_imag = s1_beat.s_imag * $signed({1'b0, s1_beat.weight});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (ready2) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_valid) begin
      s2_prod_r.p_real <= m_real[31:0];
      s2_prod_r.p_imag <= m_imag[31:0];
      s2_prod_r.ctl    <= s1_beat.ctl;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_prod  = s2_prod_r;

endmodule

// ===== hw/rtl/swc_comb.sv =====
// Operand latches and Stokes combine into the result register.
`timescale 1ns / 1ps
module swc_comb (
  input  logic               clk,
  input  logic               rst_n,
  input  swc_pkg::cfg_t      cfg,
  input  logic               s2_valid,
  input  swc_pkg::prod_t     s2_prod,
  output logic               s2_take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [33:0] out_result_real,
  output logic signed [33:0] out_result_imag,
  output logic [11:0]        out_channel_index,
  output logic [1:0]         out_status
);
  import swc_pkg::*;

  logic signed [31:0] a_re_r, a_im_r, b_re_r, b_im_r;
  logic signed [31:0] a_re_nxt, a_im_nxt, b_re_nxt, b_im_nxt;
  logic [1:0]         bad_r, bad_nxt;
  logic signed [33:0] ar, ai, br, bi;
  logic signed [33:0] res_re, res_im;
  logic [1:0]         res_st;
  logic               rdy_out;
  logic               take;
  logic               out_valid_r;
  logic signed [33:0] res_re_r, res_im_r;
  logic [11:0]        ch_r;
  logic [1:0]         st_r;

  assign rdy_out = !out_valid_r || !out_stall;
  assign s2_take = rdy_out;
  assign take    = s2_valid && rdy_out;

  // Latch this beat's product at operand positions A and B
  always_comb begin
    a_re_nxt = a_re_r;
    a_im_nxt = a_im_r;
    b_re_nxt = b_re_r;
    b_im_nxt = b_im_r;
    bad_nxt  = s2_prod.ctl.row_start ? 2'b00 : bad_r;
    if (s2_prod.ctl.pos == cfg.pa) begin
      a_re_nxt   = s2_prod.p_real;
      a_im_nxt   = s2_prod.p_imag;
      bad_nxt[0] = s2_prod.ctl.flagged;
    end
    if (s2_prod.ctl.pos == cfg.pb) begin
      b_re_nxt   = s2_prod.p_real;
      b_im_nxt   = s2_prod.p_imag;
      bad_nxt[1] = s2_prod.ctl.flagged;
    end
  end

  assign ar = 34'(a_re_nxt);
  assign ai = 34'(a_im_nxt);
  assign br = 34'(b_re_nxt);
  assign bi = 34'(b_im_nxt);

  // Combine per mode; -i rotation maps (re, im) to (im, -re)
  always_comb begin
    res_re = '0;
    res_im = '0;
    res_st = ST_OK;
    if (cfg.mode == MODE_NONE) begin
      res_st = ST_NOFORM;
    end else if (cfg.mode == MODE_COPY) begin
      if (bad_nxt[0]) begin
        res_st = ST_FLAGGED;
      end else begin
        res_re = ar;
        res_im = ai;
      end
    end else if (bad_nxt != 2'b00) begin
      res_st = ST_FLAGGED;
    end else begin
      case (cfg.mode)
        MODE_SUM: begin
          res_re = ar + br;
          res_im = ai + bi;
        end
        MODE_DIFF: begin
          res_re = ar - br;
          res_im = ai - bi;
        end
        default: begin
          res_re = ai - bi;
          res_im = br - ar;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_re_r      <= '0;
      a_im_r      <= '0;
      b_re_r      <= '0;
      b_im_r      <= '0;
      bad_r       <= 2'b00;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        a_re_r <= a_re_nxt;
        a_im_r <= a_im_nxt;
        b_re_r <= b_re_nxt;
        b_im_r <= b_im_nxt;
        bad_r  <= bad_nxt;
      end
      if (rdy_out) out_valid_r <= s2_valid && s2_prod.ctl.emit;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (take && s2_prod.ctl.emit) begin
      res_re_r <= res_re;
      res_im_r <= res_im;
      ch_r     <= s2_prod.ctl.ch;
      st_r     <= res_st;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_real   = res_re_r;
  assign out_result_imag   = res_im_r;
  assign out_channel_index = ch_r;
  assign out_status        = st_r;

endmodule

// ===== hw/rtl/stokes_weighted_combiner.sv =====
// Top level of the weighted correlation-to-Stokes combiner.
// Path: a channel's last input beat passes the input register, the weight-multiply register
//   and the result register before its result beat shows on out_valid.
// Throughput: one input beat per cycle; stall from the output ripples back through all stages.
// Reset (rst_n low, synchronous): registers return to defaults, counters and operand
//   latches clear, and the pipe empties.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stokes_weighted_combiner #(
  parameter int MAX_CHANNELS = swc_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_POLS     = swc_pkg::DEF_MAX_POLS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample_real,
  input  logic signed [15:0] in_sample_imag,
  input  logic [15:0]        in_weight,
  input  logic               in_flagged,
  input  logic               in_row_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [33:0] out_result_real,
  output logic signed [33:0] out_result_imag,
  output logic [11:0]        out_channel_index,
  output logic [1:0]         out_status
);
  import swc_pkg::*;

  cfg_t  cfg;
  logic  s1_valid, s1_take;
  beat_t s1_beat;
  logic  s2_valid, s2_take;
  prod_t s2_prod;

  // Register file and mode decode
  swc_cfg #(.MAX_POLS(MAX_POLS)) u_cfg (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cfg(cfg)
  );

  // Position and channel tracking, input register
  swc_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_real(in_sample_real), .in_sample_imag(in_sample_imag),
    .in_weight(in_weight), .in_flagged(in_flagged), .in_row_start(in_row_start),
    .s1_valid(s1_valid), .s1_beat(s1_beat), .s1_take(s1_take)
  );

  // Weight multiply
  swc_mult u_mult (
    .clk(clk), .rst_n(rst_n),
    .s1_valid(s1_valid), .s1_beat(s1_beat), .s1_take(s1_take),
    .s2_valid(s2_valid), .s2_prod(s2_prod), .s2_take(s2_take)
  );

  // Operand latches and combine
  swc_comb u_comb (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .s2_valid(s2_valid), .s2_prod(s2_prod), .s2_take(s2_take),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_real(out_result_real), .out_result_imag(out_result_imag),
    .out_channel_index(out_channel_index), .out_status(out_status)
  );

  // Checks
  `SWC_ASSERT_IMP(a_zero_on_error, clk, rst_n, out_valid && (out_status != ST_OK), (out_result_real == '0) && (out_result_imag == '0), "nonzero value on error status")
  `SWC_ASSERT_IMP(a_stall_only_full, clk, rst_n, in_stall, s1_valid && s2_valid && out_valid && out_stall, "input stalled with room in pipe")
  `SWC_ASSERT_NXT(a_out_drains, clk, rst_n, !s2_valid && !out_stall, !out_valid, "result beat without source")

endmodule

// ===== dv/stokes_weighted_combiner_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for stokes_weighted_combiner: predicts each result and checks it per beat.
module stokes_weighted_combiner_test;
  import swc_pkg::*;

  localparam int CHANNELS       = 4096;
  localparam int SETTLE         = 8;     // pipe is 3 deep, plus margin
  localparam int WATCHDOG_LIMIT = 4000;

  // One correlation sample beat
  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [15:0]        w;
    logic               flag;
    logic               row;
  } corr_t;

  // One output visibility beat
  typedef struct packed {
    logic signed [33:0] re;
    logic signed [33:0] im;
    logic [11:0]        ch;
    logic [1:0]         status;
  } vis_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_sample_real = '0;
  logic signed [15:0] in_sample_imag = '0;
  logic [15:0]        in_weight = '0;
  logic               in_flagged = 1'b0;
  logic               in_row_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [33:0] out_result_real;
  logic signed [33:0] out_result_imag;
  logic [11:0]        out_channel_index;
  logic [1:0]         out_status;

  stokes_weighted_combiner dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_real(in_sample_real), .in_sample_imag(in_sample_imag),
    .in_weight(in_weight), .in_flagged(in_flagged), .in_row_start(in_row_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_real(out_result_real), .out_result_imag(out_result_imag),
    .out_channel_index(out_channel_index), .out_status(out_status)
  );

  // Shadow of the register file
  logic [2:0]  n_pols_reg = 3'd4;
  logic [3:0]  pol_map [4] = '{POL_XX, POL_XY, POL_YX, POL_YY};
  logic [3:0]  want_pol = POL_I;
  logic [11:0] win_lo = '0;
  logic [12:0] win_hi = 13'd4096;

  // Shadow of the datapath state
  logic [1:0]  pol_idx = '0;
  int          chan_cnt = 0;
  longint      a_re = 0, a_im = 0, b_re = 0, b_im = 0;
  logic [1:0]  bad_ab = '0;
  logic [2:0]  op_mode;
  logic [1:0]  op_a, op_b;

  vis_t expected_vis [$];
  int   errors = 0;
  int   quiet_cycles = 0;
  int   hold_left = 0;
  bit   no_idle = 1'b0;
  vis_t seen_vis, due_vis;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic int active_pols();
    int c;
    c = n_pols_reg;
    if (c < 1) c = 1;
    if (c > 4) c = 4;
    return c;
  endfunction

  // First active position carrying a code, -1 if none
  function automatic int locate_pol(input logic [3:0] code);
    int n;
    n = active_pols();
    for (int i = 0; i < n; i++) begin
      if (pol_map[i] == code) return i;
    end
    return -1;
  endfunction

  // A partial match still moves operand A, as the block does
  function automatic bit pair_at(input logic [3:0] ca, input logic [3:0] cb);
    int k;
    k = locate_pol(ca);
    if (k < 0) return 1'b0;
    op_a = k[1:0];
    k = locate_pol(cb);
    if (k < 0) return 1'b0;
    op_b = k[1:0];
    return 1'b1;
  endfunction

  function automatic void choose_op();
    int k;
    op_a = '0;
    op_b = '0;
    op_mode = MODE_NONE;
    if (want_pol > POL_V) return;
    k = locate_pol(want_pol);
    if (k >= 0) begin
      op_a = k[1:0];
      op_b = k[1:0];
      op_mode = MODE_COPY;
      return;
    end
    case (want_pol)
      POL_I: if (pair_at(POL_XX, POL_YY)) op_mode = MODE_SUM;
             else if (pair_at(POL_RR, POL_LL)) op_mode = MODE_SUM;
      POL_Q: if (pair_at(POL_XX, POL_YY)) op_mode = MODE_DIFF;
             else if (pair_at(POL_RL, POL_LR)) op_mode = MODE_SUM;
      POL_U: if (pair_at(POL_XY, POL_YX)) op_mode = MODE_SUM;
             else if (pair_at(POL_RL, POL_LR)) op_mode = MODE_ROT;
      POL_V: if (pair_at(POL_XY, POL_YX)) op_mode = MODE_ROT;
             else if (pair_at(POL_RR, POL_LL)) op_mode = MODE_DIFF;
      default: ;
    endcase
  endfunction

  // Advance the shadow state by one sample; returns 1 when a visibility is due
  function automatic bit combine_sample(input corr_t c, output vis_t v);
    longint sr, si, w, rr, ri;
    logic [1:0] pos;
    logic [1:0] st;
    int n, ch;
    sr = c.re;
    si = c.im;
    w = c.w;
    rr = 0;
    ri = 0;
    st = ST_OK;
    v = '0;
    if (c.row) begin
      pol_idx = '0;
      chan_cnt = 0;
      bad_ab = '0;
    end
    choose_op();
    pos = pol_idx;
    n = active_pols();
    if (pos == op_a) begin
      a_re = sr * w;
      a_im = si * w;
      bad_ab[0] = c.flag;
    end
    if (pos == op_b) begin
      b_re = sr * w;
      b_im = si * w;
      bad_ab[1] = c.flag;
    end
    if (int'(pos) + 1 < n) begin
      pol_idx = pos + 2'd1;
      return 1'b0;
    end
    // last position of the channel
    ch = chan_cnt;
    pol_idx = '0;
    if (chan_cnt < CHANNELS) chan_cnt++;
    if (!(ch >= win_lo && ch < win_hi && ch < CHANNELS)) return 1'b0;
    if (op_mode == MODE_NONE) begin
      st = ST_NOFORM;
    end else if (op_mode == MODE_COPY) begin
      if (bad_ab[0]) st = ST_FLAGGED;
      else begin
        rr = a_re;
        ri = a_im;
      end
    end else if (bad_ab != 2'b00) begin
      st = ST_FLAGGED;
    end else begin
      case (op_mode)
        MODE_SUM: begin
          rr = a_re + b_re;
          ri = a_im + b_im;
        end
        MODE_DIFF: begin
          rr = a_re - b_re;
          ri = a_im - b_im;
        end
        default: begin
          // -i rotation of A-B
          rr = a_im - b_im;
          ri = -(a_re - b_re);
        end
      endcase
    end
    v.re = rr[33:0];
    v.im = ri[33:0];
    v.ch = ch[11:0];
    v.status = st;
    return 1'b1;
  endfunction

  // ---------------- drivers ----------------

  function automatic corr_t corr(input logic [15:0] re, input logic [15:0] im,
                                 input logic [15:0] w, input logic flag, input logic row);
    corr_t c;
    c.re = re;
    c.im = im;
    c.w = w;
    c.flag = flag;
    c.row = row;
    return c;
  endfunction

  // Mostly random, with the range ends and zero mixed in
  function automatic logic [15:0] spread16(input logic [15:0] lo_end, input logic [15:0] hi_end);
    case ($urandom_range(0, 9))
      0: return lo_end;
      1: return hi_end;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic corr_t rand_corr();
    return corr(spread16(16'h8000, 16'h7FFF), spread16(16'h8000, 16'h7FFF),
                spread16(16'h0100, 16'hFFFF), $urandom_range(0, 99) < 8, 1'b0);
  endfunction

  // Offer one beat and wait until it is taken
  task automatic send_corr(input corr_t c);
    vis_t v;
    if (!no_idle && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample_real <= c.re;
    in_sample_imag <= c.im;
    in_weight      <= c.w;
    in_flagged     <= c.flag;
    in_row_start   <= c.row;
    do @(posedge clk); while (in_stall);
    if (combine_sample(c, v)) expected_vis.insert(expected_vis.size(), v);
  endtask

  // Stop sending, let every due result arrive, then let the pipe empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_vis.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_POL_COUNT: n_pols_reg = val[2:0];
      REG_POL_TYPE_0, REG_POL_TYPE_1, REG_POL_TYPE_2, REG_POL_TYPE_3:
        pol_map[idx - REG_POL_TYPE_0] = val[3:0];
      REG_OUTPUT_POL: want_pol = val[3:0];
      REG_START_CH: win_lo = val[11:0];
      REG_END_CH: win_hi = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [2:0] cnt, input logic [3:0] t0, input logic [3:0] t1,
                           input logic [3:0] t2, input logic [3:0] t3, input logic [3:0] outp,
                           input logic [11:0] lo, input logic [12:0] hi);
    write_reg(REG_POL_COUNT, 32'(cnt));
    write_reg(REG_POL_TYPE_0, 32'(t0));
    write_reg(REG_POL_TYPE_1, 32'(t1));
    write_reg(REG_POL_TYPE_2, 32'(t2));
    write_reg(REG_POL_TYPE_3, 32'(t3));
    write_reg(REG_OUTPUT_POL, 32'(outp));
    write_reg(REG_START_CH, 32'(lo));
    write_reg(REG_END_CH, 32'(hi));
  endtask

  // ---------------- receiver and checker ----------------

  // Random stall unless no_idle is set; a counted hold when requested, also while no_idle is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 20);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_vis = {out_result_real, out_result_imag, out_channel_index, out_status};
      if (expected_vis.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: re %0d im %0d ch %0d status %0d",
                   seen_vis.re, seen_vis.im, seen_vis.ch, seen_vis.status);
      end else begin
        due_vis = expected_vis.pop_front();
        if (seen_vis.re !== due_vis.re || seen_vis.im !== due_vis.im ||
            seen_vis.ch !== due_vis.ch || seen_vis.status !== due_vis.status) begin
          errors++;
          if (errors <= 10)
            $display("ch %0d: expected re %0d im %0d ch %0d st %0d, got re %0d im %0d ch %0d st %0d",
                     due_vis.ch, due_vis.re, due_vis.im, due_vis.ch, due_vis.status,
                     seen_vis.re, seen_vis.im, seen_vis.ch, seen_vis.status);
        end
      end
    end
  end

  // Watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------- tests ----------------

  // Reset settings: Stokes I from linear products, range ends of the sample and weight fields
  task automatic test_defaults();
    send_corr(corr(16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 1'b1));
    send_corr(corr(16'h1234, 16'h4321, 16'h0100, 1'b0, 1'b0));
    send_corr(corr(16'hFFFF, 16'h0001, 16'h0000, 1'b0, 1'b0));
    send_corr(corr(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, 1'b0));
    wait_idle();
  endtask

  // A flag on a used operand zeroes the result, on an unused one it does not
  task automatic test_flagged();
    configure(3'd4, POL_XX, POL_XY, POL_YX, POL_YY, POL_Q, 12'd0, 13'd4096);
    send_corr(corr(16'h4000, 16'hC000, 16'h0200, 1'b0, 1'b1));
    send_corr(corr(16'h0100, 16'h0100, 16'h0100, 1'b0, 1'b0));
    send_corr(corr(16'h0100, 16'h0100, 16'h0100, 1'b0, 1'b0));
    send_corr(corr(16'h2000, 16'h2000, 16'h0300, 1'b1, 1'b0));
    send_corr(corr(16'h4000, 16'hC000, 16'h0200, 1'b0, 1'b0));
    send_corr(corr(16'h0100, 16'h0100, 16'h0100, 1'b1, 1'b0));
    send_corr(corr(16'h0100, 16'h0100, 16'h0100, 1'b0, 1'b0));
    send_corr(corr(16'h2000, 16'h7000, 16'h0300, 1'b0, 1'b0));
    wait_idle();
  endtask

  // Count 0 behaves as 1, count above four as four
  task automatic test_count_limits();
    configure(3'd0, POL_RR, POL_RL, POL_LR, POL_LL, POL_RR, 12'd0, 13'd4096);
    send_corr(corr(16'h1111, 16'h2222, 16'h0180, 1'b0, 1'b1));
    send_corr(corr(16'h3333, 16'h4444, 16'h0180, 1'b1, 1'b0));
    wait_idle();
    configure(3'd7, POL_RR, POL_RL, POL_LR, POL_LL, POL_U, 12'd0, 13'd4096);
    send_corr(corr(16'h1000, 16'h2000, 16'h0100, 1'b0, 1'b1));
    send_corr(corr(16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 1'b0));
    send_corr(corr(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, 1'b0));
    send_corr(corr(16'h1000, 16'h2000, 16'h0100, 1'b0, 1'b0));
    wait_idle();
  endtask

  // Unknown codes and outputs that cannot be formed report status 2
  task automatic test_unknown_codes();
    configure(3'd2, 4'd12, 4'd15, POL_XX, POL_YY, 4'd13, 12'd0, 13'd4096);
    send_corr(corr(16'h0100, 16'h0200, 16'h0100, 1'b1, 1'b1));
    send_corr(corr(16'h0300, 16'h0400, 16'h0100, 1'b0, 1'b0));
    wait_idle();
    write_reg(REG_OUTPUT_POL, 32'(POL_I));
    send_corr(corr(16'h0100, 16'h0200, 16'h0100, 1'b0, 1'b0));
    send_corr(corr(16'h0300, 16'h0400, 16'h0100, 1'b0, 1'b0));
    wait_idle();
  endtask

  // Shrinking the count mid-channel ends the channel at the current position
  task automatic test_beyond_count();
    configure(3'd4, POL_XX, POL_XY, POL_YX, POL_YY, POL_XY, 12'd0, 13'd4096);
    send_corr(corr(16'h0101, 16'h0202, 16'h0100, 1'b0, 1'b1));
    send_corr(corr(16'h0303, 16'h0404, 16'h0200, 1'b0, 1'b0));
    send_corr(corr(16'h0505, 16'h0606, 16'h0300, 1'b0, 1'b0));
    wait_idle();
    write_reg(REG_POL_COUNT, 32'd2);
    send_corr(corr(16'h0707, 16'h0808, 16'h0400, 1'b0, 1'b0));
    send_corr(corr(16'h0909, 16'h0A0A, 16'h0500, 1'b0, 1'b0));
    send_corr(corr(16'h0B0B, 16'h0C0C, 16'h0600, 1'b0, 1'b0));
    wait_idle();
  endtask

  // Window bounds, including an empty window
  task automatic test_window_edges();
    configure(3'd1, POL_XX, POL_XY, POL_YX, POL_YY, POL_XX, 12'd2, 13'd5);
    for (int i = 0; i < 7; i++) send_corr(corr(16'(i * 77), 16'(-i), 16'h0100, 1'b0, i == 0));
    wait_idle();
    write_reg(REG_START_CH, 32'd4095);
    write_reg(REG_END_CH, 32'd0);
    send_corr(corr(16'h0100, 16'h0100, 16'h0100, 1'b0, 1'b1));
    send_corr(corr(16'h0100, 16'h0100, 16'h0100, 1'b0, 1'b0));
    wait_idle();
  endtask

  // Output held off for a long stretch while input keeps coming, then drain
  task automatic test_backpressure();
    configure(3'd4, POL_XX, POL_XY, POL_YX, POL_YY, POL_I, 12'd0, 13'd4096);
    no_idle = 1'b1;
    hold_left = 300;
    for (int i = 0; i < 64; i++) begin
      corr_t c;
      c = rand_corr();
      c.row = (i == 0);
      send_corr(c);
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  // Random settings per phase; mostly well-formed rows, some broken ones
  task automatic test_random_rows();
    logic [3:0] map [4];
    logic [3:0] tmp, outp;
    logic [2:0] cnt;
    logic [11:0] lo;
    logic [12:0] hi;
    int j, r, sent, nch, npol;
    corr_t c;
    for (int phase = 0; phase < 16; phase++) begin
      if (phase % 2 == 0) map = '{POL_XX, POL_XY, POL_YX, POL_YY};
      else map = '{POL_RR, POL_RL, POL_LR, POL_LL};
      for (int i = 3; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = map[i];
        map[i] = map[j];
        map[j] = tmp;
      end
      if (phase < 8) begin
        // every Stokes output from both bases
        cnt = 3'd4;
        outp = POL_I + 4'(phase / 2);
        lo = '0;
        hi = 13'd4096;
      end else begin
        if ($urandom_range(0, 5) == 0) map[$urandom_range(0, 3)] = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 9);
        cnt = (r < 6) ? 3'd4 : (r < 8) ? 3'($urandom_range(1, 3)) : 3'($urandom_range(0, 7));
        r = $urandom_range(0, 9);
        outp = (r < 7) ? POL_I + 4'($urandom_range(0, 3)) :
               (r < 9) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(12, 15));
        lo = 12'($urandom_range(0, 3));
        r = $urandom_range(0, 9);
        hi = (r < 6) ? 13'd4096 : (r < 8) ? 13'($urandom_range(1, 14)) :
             (r == 8) ? 13'(lo) : 13'd0;
      end
      configure(cnt, map[0], map[1], map[2], map[3], outp, lo, hi);
      npol = active_pols();
      no_idle = (phase == 10 || phase == 11);
      sent = 0;
      while (sent < 65) begin
        if ($urandom_range(0, 99) < 10) begin
          // broken row: random length, stray row starts
          repeat ($urandom_range(1, 7)) begin
            c = rand_corr();
            c.row = $urandom_range(0, 1);
            send_corr(c);
            sent++;
          end
        end else begin
          nch = $urandom_range(1, 12);
          for (int ch = 0; ch < nch; ch++) begin
            for (int p = 0; p < npol; p++) begin
              c = rand_corr();
              c.row = (ch == 0 && p == 0);
              send_corr(c);
              sent++;
            end
          end
        end
      end
      no_idle = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_flagged();
    test_count_limits();
    test_unknown_codes();
    test_beyond_count();
    test_window_edges();
    test_backpressure();
    test_random_rows();
    if (errors == 0 && expected_vis.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== stokes_weighted_combiner.f =====
+incdir+hw/rtl
hw/rtl/swc_pkg.sv
hw/rtl/swc_cfg.sv
hw/rtl/swc_front.sv
hw/rtl/swc_mult.sv
hw/rtl/swc_comb.sv
hw/rtl/stokes_weighted_combiner.sv
dv/stokes_weighted_combiner_test.sv
